// ----- hdl/q4k_pkg.sv -----
package q4k_pkg;

    localparam int unsigned SbBytes    = 144;
    localparam int unsigned HdrBytes   = 16;
    localparam int unsigned ChunkBytes = 32;
    localparam int unsigned RunLen     = 64;

    localparam logic [15:0] HalfQnan = 16'h7E00;
    localparam logic [14:0] HalfInf  = 15'h7C00;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_PREP,
        SQ_ISSUE,
        SQ_WAIT
    } t_seq_state;

    typedef enum logic [2:0] {
        DP_IDLE,
        DP_PROD,
        DP_ALIGN,
        DP_NORM,
        DP_R32,
        DP_R16,
        DP_DONE
    } t_dp_state;

    // one element's operands, handed from the sequencer to the arithmetic unit
    typedef struct packed {
        logic [16:0] pa;      // scale significand * sub-scale
        logic [16:0] pb;      // min significand * sub-min
        logic [3:0]  q;
        logic [4:0]  ea;      // biased exponents, subnormals as 1
        logic [4:0]  eb;
        logic        sa;
        logic        sb;
        logic        a_inf;
        logic        a_nan;
        logic        b_inf;
        logic        b_nan;
        logic        sc_zero;
        logic        mn_zero;
    } t_dp_req;

    typedef struct packed {
        logic start;
        logic ack;
    } t_dp_ctl;

endpackage

// ----- hdl/q4k_dp.sv -----
module q4k_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  q4k_pkg::t_dp_ctl i_ctl,
    input  q4k_pkg::t_dp_req i_req,
    output logic             o_done,
    output logic [15:0]      o_result
);

    q4k_pkg::t_dp_state r_state, n_state;

    q4k_pkg::t_dp_req r_req;
    logic [20:0]        r_ma;
    logic [50:0]        r_mag;
    logic               r_neg;
    logic [4:0]         r_emin;
    logic [5:0]         r_s;
    logic [23:0]        r_m24;
    logic signed [7:0]  r_he;
    logic [15:0]        r_res;

    // combinational pieces
    logic        a_nan, a_inf, b_nan, b_inf, res_nan, res_inf, res_sgn;
    logic [4:0]  sh;
    logic [50:0] a_al, b_al;
    logic signed [51:0] sva, svb, diff;
    logic [50:0] mag;
    logic [24:0] m_rnd;
    logic        inc32;
    logic [4:0]  sub_sh;
    logic [47:0] w;
    logic [14:0] h;
    logic        guard, sticky, inc16;
    logic [15:0] half;

    assign o_done   = (r_state == q4k_pkg::DP_DONE);
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= q4k_pkg::DP_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        a_nan   = r_req.a_nan | (r_req.a_inf & (r_req.sc_zero | (r_req.q == 4'd0)));
        a_inf   = r_req.a_inf & !a_nan;
        b_nan   = r_req.b_nan | (r_req.b_inf & r_req.mn_zero);
        b_inf   = r_req.b_inf & !b_nan;
        res_nan = a_nan | b_nan | (a_inf & b_inf & (r_req.sa == r_req.sb));
        res_inf = a_inf | b_inf;
        res_sgn = a_inf ? r_req.sa : !r_req.sb;

        sh   = (r_req.ea >= r_req.eb) ? (r_req.ea - r_req.eb) : (r_req.eb - r_req.ea);
        a_al = (r_req.ea >= r_req.eb) ? (51'(r_ma) << sh) : 51'(r_ma);
        b_al = (r_req.ea >= r_req.eb) ? 51'(r_req.pb) : (51'(r_req.pb) << sh);
        sva  = r_req.sa ? -$signed({1'b0, a_al}) : $signed({1'b0, a_al});
        svb  = r_req.sb ? -$signed({1'b0, b_al}) : $signed({1'b0, b_al});
        diff = sva - svb;
        mag  = diff[51] ? 51'(-diff) : diff[50:0];

        // fp32 round to nearest even on the normalized magnitude
        inc32 = r_mag[26] & ((|r_mag[25:0]) | r_mag[27]);
        m_rnd = {1'b0, r_mag[50:27]} + 25'(inc32);

        // fp16 rounding of the fp32 value
        sub_sh = 5'(8'sd14 - r_he);
        w      = {r_m24, 24'd0} >> sub_sh;
        if (r_he > 8'sd0) begin
            h      = {r_he[4:0], r_m24[22:13]};
            guard  = r_m24[12];
            sticky = |r_m24[11:0];
        end else begin
            h      = w[38:24];
            guard  = w[23];
            sticky = |w[22:0];
        end
        inc16 = guard & (sticky | h[0]);
        if (r_he >= 8'sd31) begin
            half = {r_neg, q4k_pkg::HalfInf};
        end else if (r_he < -8'sd10) begin
            half = {r_neg, 15'd0};
        end else begin
            half = {r_neg, h + 15'(inc16)};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            q4k_pkg::DP_IDLE:  if (i_ctl.start) n_state = q4k_pkg::DP_PROD;
            q4k_pkg::DP_PROD:  n_state = q4k_pkg::DP_ALIGN;
            q4k_pkg::DP_ALIGN: begin
                if (res_nan || res_inf) begin
                    n_state = q4k_pkg::DP_DONE;
                end else if (mag == 51'd0) begin
                    n_state = q4k_pkg::DP_DONE;
                end else begin
                    n_state = q4k_pkg::DP_NORM;
                end
            end
            q4k_pkg::DP_NORM:  if (r_mag[50]) n_state = q4k_pkg::DP_R32;
            q4k_pkg::DP_R32:   n_state = q4k_pkg::DP_R16;
            q4k_pkg::DP_R16:   n_state = q4k_pkg::DP_DONE;
            q4k_pkg::DP_DONE:  if (i_ctl.ack) n_state = q4k_pkg::DP_IDLE;
            default:           n_state = q4k_pkg::DP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            q4k_pkg::DP_IDLE: begin
                if (i_ctl.start) r_req <= i_req;
            end
            q4k_pkg::DP_PROD: begin
                r_ma <= 21'(r_req.pa) * 21'(r_req.q);
            end
            q4k_pkg::DP_ALIGN: begin
                r_mag  <= mag;
                r_neg  <= diff[51];
                r_emin <= (r_req.ea >= r_req.eb) ? r_req.eb : r_req.ea;
                r_s    <= 6'd0;
                if (res_nan) begin
                    r_res <= q4k_pkg::HalfQnan;
                end else if (res_inf) begin
                    r_res <= {res_sgn, q4k_pkg::HalfInf};
                end else begin
                    // exact zero: negative only for -0 minus +0
                    r_res <= {r_req.sa & !r_req.sb & (r_ma == 21'd0), 15'd0};
                end
            end
            q4k_pkg::DP_NORM: begin
                priority if (r_mag[50]) begin
                end else if (r_mag[50:35] == 16'd0) begin
                    r_mag <= r_mag << 16;
                    r_s   <= r_s + 6'd16;
                end else if (r_mag[50:47] == 4'd0) begin
                    r_mag <= r_mag << 4;
                    r_s   <= r_s + 6'd4;
                end else begin
                    r_mag <= r_mag << 1;
                    r_s   <= r_s + 6'd1;
                end
            end
            q4k_pkg::DP_R32: begin
                r_m24 <= m_rnd[24] ? 24'h800000 : m_rnd[23:0];
                r_he  <= $signed(8'(r_emin) + 8'd40 - 8'(r_s) + 8'(m_rnd[24]));
            end
            q4k_pkg::DP_R16: begin
                r_res <= half;
            end
            q4k_pkg::DP_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- hdl/q4k_superblock_dequantizer_core.sv -----
// Q4_K super-block dequantizer.
// Input channel: one raw byte per word (i_data_byte, i_final_block) on
// i_in_valid / o_in_ready. Bytes come in file order, 144 per super-block.
// Output channel: one fp16 element per word (o_half_value, o_element_index,
// o_run_last, o_tensor_end) on o_out_valid / i_out_ready.
// Header and chunk bytes can be accepted back to back. The 32nd byte of a chunk
// starts a run of 64 elements; o_in_ready stays low until the run is done.
// Each element passes through one shared fp unit, one element at a time:
// product, align/subtract, leading-one shift, fp32 round, fp16 round; a zero,
// NaN or infinite result skips the shift and both rounds. Operand setup
// (sub-scale and sub-min products) runs once per 32 elements.
// The multiplies are exact; only the fp32 subtract and the fp16
// conversion round, both to nearest even. NaN comes out as 0x7E00.
// A stalled receiver holds the output word; the fp unit finishes the next
// element and then waits. Reset returns the byte counter to the start of a
// super-block and clears the scale and minimum.
module q4k_superblock_dequantizer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_block,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_half_value,
    output logic [7:0]  o_element_index,
    output logic        o_run_last,
    output logic        o_tensor_end
);

    q4k_pkg::t_seq_state r_state, n_state;

    logic [15:0] r_scale, r_min;
    logic [7:0]  r_sub [12];
    logic [7:0]  r_buf [32];
    logic [7:0]  r_pos;
    logic [1:0]  r_c;
    logic        r_fin;
    logic [5:0]  r_k;
    logic [16:0] r_pa, r_pb;
    logic        r_sc_zero, r_mn_zero;
    logic        r_out_valid;
    logic [15:0] r_half;
    logic [7:0]  r_idx;
    logic        r_last, r_tend;

    logic        acc;
    logic [7:0]  off;
    logic        chunk_end;
    logic [2:0]  j;
    logic [5:0]  sc, mn;
    logic [10:0] md, mm;
    logic [7:0]  qb;
    logic        take;
    q4k_pkg::t_dp_req req;
    q4k_pkg::t_dp_ctl ctl;
    logic        dp_done;
    logic [15:0] dp_res;

    assign o_in_ready      = (r_state == q4k_pkg::SQ_IDLE);
    assign acc             = i_in_valid && o_in_ready;
    assign off             = r_pos - 8'(q4k_pkg::HdrBytes);
    assign chunk_end       = (r_pos >= 8'(q4k_pkg::HdrBytes)) && (off[4:0] == 5'd31);
    assign o_out_valid     = r_out_valid;
    assign o_half_value    = r_half;
    assign o_element_index = r_idx;
    assign o_run_last      = r_last;
    assign o_tensor_end    = r_tend;

    assign take = (r_state == q4k_pkg::SQ_WAIT) && dp_done && (!r_out_valid || i_out_ready);
    assign j    = {r_c, r_k[5]};
    assign md   = {r_scale[14:10] != 5'd0, r_scale[9:0]};
    assign mm   = {r_min[14:10] != 5'd0, r_min[9:0]};
    assign qb   = r_buf[r_k[4:0]];

    always_comb begin
        unique case (j)
            3'd0: begin sc = r_sub[0][5:0]; mn = r_sub[4][5:0]; end
            3'd1: begin sc = r_sub[1][5:0]; mn = r_sub[5][5:0]; end
            3'd2: begin sc = r_sub[2][5:0]; mn = r_sub[6][5:0]; end
            3'd3: begin sc = r_sub[3][5:0]; mn = r_sub[7][5:0]; end
            3'd4: begin sc = {r_sub[0][7:6], r_sub[8][3:0]};  mn = {r_sub[4][7:6], r_sub[8][7:4]};  end
            3'd5: begin sc = {r_sub[1][7:6], r_sub[9][3:0]};  mn = {r_sub[5][7:6], r_sub[9][7:4]};  end
            3'd6: begin sc = {r_sub[2][7:6], r_sub[10][3:0]}; mn = {r_sub[6][7:6], r_sub[10][7:4]}; end
            3'd7: begin sc = {r_sub[3][7:6], r_sub[11][3:0]}; mn = {r_sub[7][7:6], r_sub[11][7:4]}; end
            default: begin sc = 6'd0; mn = 6'd0; end
        endcase
    end

    always_comb begin
        req.pa      = r_pa;
        req.pb      = r_pb;
        req.q       = r_k[5] ? qb[7:4] : qb[3:0];
        req.ea      = (r_scale[14:10] == 5'd0) ? 5'd1 : r_scale[14:10];
        req.eb      = (r_min[14:10] == 5'd0) ? 5'd1 : r_min[14:10];
        req.sa      = r_scale[15];
        req.sb      = r_min[15];
        req.a_inf   = (r_scale[14:10] == 5'h1F) && (r_scale[9:0] == 10'd0);
        req.a_nan   = (r_scale[14:10] == 5'h1F) && (r_scale[9:0] != 10'd0);
        req.b_inf   = (r_min[14:10] == 5'h1F) && (r_min[9:0] == 10'd0);
        req.b_nan   = (r_min[14:10] == 5'h1F) && (r_min[9:0] != 10'd0);
        req.sc_zero = r_sc_zero;
        req.mn_zero = r_mn_zero;
        ctl.start   = (r_state == q4k_pkg::SQ_ISSUE);
        ctl.ack     = take;
    end

    q4k_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_req   (req),
        .o_done  (dp_done),
        .o_result(dp_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            q4k_pkg::SQ_IDLE:  if (acc && chunk_end) n_state = q4k_pkg::SQ_PREP;
            q4k_pkg::SQ_PREP:  n_state = q4k_pkg::SQ_ISSUE;
            q4k_pkg::SQ_ISSUE: n_state = q4k_pkg::SQ_WAIT;
            q4k_pkg::SQ_WAIT: begin
                if (take) begin
                    priority if (r_k == 6'(q4k_pkg::RunLen - 1)) begin
                        n_state = q4k_pkg::SQ_IDLE;
                    end else if (r_k == 6'(q4k_pkg::ChunkBytes - 1)) begin
                        n_state = q4k_pkg::SQ_PREP;
                    end else begin
                        n_state = q4k_pkg::SQ_ISSUE;
                    end
                end
            end
            default: n_state = q4k_pkg::SQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= q4k_pkg::SQ_IDLE;
            r_pos       <= 8'd0;
            r_scale     <= 16'd0;
            r_min       <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc) begin
                r_pos <= (r_pos == 8'(q4k_pkg::SbBytes - 1)) ? 8'd0 : r_pos + 8'd1;
                unique case (r_pos)
                    8'd0: r_scale[7:0]  <= i_data_byte;
                    8'd1: r_scale[15:8] <= i_data_byte;
                    8'd2: r_min[7:0]    <= i_data_byte;
                    8'd3: r_min[15:8]   <= i_data_byte;
                    default: begin
                    end
                endcase
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            if (r_pos >= 8'd4 && r_pos < 8'(q4k_pkg::HdrBytes)) begin
                r_sub[4'(r_pos - 8'd4)] <= i_data_byte;
            end
            if (r_pos >= 8'(q4k_pkg::HdrBytes)) begin
                r_buf[off[4:0]] <= i_data_byte;
            end
            if (chunk_end) begin
                r_c   <= off[6:5];
                r_fin <= i_final_block;
                r_k   <= 6'd0;
            end
        end
        if (r_state == q4k_pkg::SQ_PREP) begin
            r_pa      <= 17'(md) * 17'(sc);
            r_pb      <= 17'(mm) * 17'(mn);
            r_sc_zero <= (sc == 6'd0);
            r_mn_zero <= (mn == 6'd0);
        end
        if (take) begin
            r_half <= dp_res;
            r_idx  <= {r_c, r_k};
            r_last <= (r_k == 6'(q4k_pkg::RunLen - 1));
            r_tend <= (r_k == 6'(q4k_pkg::RunLen - 1)) && (r_c == 2'd3) && r_fin;
            r_k    <= r_k + 6'd1;
        end
    end

endmodule

// ----- hdl/q4k_chk.sv -----
module q4k_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_half_value,
    input logic [7:0]  o_element_index,
    input logic        o_run_last,
    input logic        o_tensor_end
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_half_value)
            && $stable(o_element_index))
        else $error("output word changed while stalled");

    a_tend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tensor_end |-> o_run_last)
        else $error("tensor end without run end");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_run_last |-> o_element_index[5:0] == 6'h3F)
        else $error("run end at wrong element");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind q4k_superblock_dequantizer_core q4k_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_half_value   (o_half_value),
    .o_element_index(o_element_index),
    .o_run_last     (o_run_last),
    .o_tensor_end   (o_tensor_end)
);

// ----- tb/tb_q4k_superblock_dequantizer_core.sv -----
module tb_q4k_superblock_dequantizer_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] half_value;
        logic [7:0]  element_index;
        logic        run_last;
        logic        tensor_end;
    } t_elem;

    // Dequantization predictor: tracks the byte stream and queues expected elements
    class dequant_scoreboard;
        logic [15:0] scale_h;
        logic [15:0] min_h;
        logic [7:0]  subs [12];
        logic [7:0]  chunk [32];
        int unsigned pos;
        t_elem       pending_q [$];
        int          n_fail;

        function void clear();
            scale_h = '0;
            min_h   = '0;
            pos     = 0;
            n_fail  = 0;
            foreach (subs[i]) subs[i] = '0;
            foreach (chunk[i]) chunk[i] = '0;
            pending_q.delete();
        endfunction

        function real half_to_real(logic [15:0] h);
            logic [4:0] ex;
            ex = h[14:10];
            if (ex == 5'h1F) return $bitstoreal({h[15], 11'h7FF, h[9:0], 42'b0});
            if (ex != 0) return $bitstoreal({h[15], 11'(ex + 1008), h[9:0], 42'b0});
            if (h[9:0] == 0) return $bitstoreal({h[15], 63'b0});
            return h[15] ? -(h[9:0] / 16777216.0) : (h[9:0] / 16777216.0);
        endfunction

        // values are multiples of 2^-24 below 2^27, so no fp32 subnormals arise
        function logic [31:0] real_to_f32(real v);
            logic [63:0] d;
            logic [31:0] r;
            logic [28:0] rem;
            int          e32;
            d = $realtobits(v);
            if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? 32'h7FC0_0000 : {d[63], 8'hFF, 23'b0};
            if (d[62:52] == 0) return {d[63], 31'b0};
            e32 = int'(d[62:52]) - 1023 + 127;
            r   = {1'b0, 8'(e32), d[51:29]};
            rem = d[28:0];
            if (rem > 29'h1000_0000 || (rem == 29'h1000_0000 && r[0])) r++;
            return {d[63], r[30:0]};
        endfunction

        function logic [15:0] f32_to_half(logic [31:0] b);
            logic [15:0] sgn;
            logic [31:0] m, h, rem, hf;
            int          e, sh;
            sgn = {b[31], 15'b0};
            if (b[30:23] == 8'hFF) return (b[22:0] != 0) ? q4k_pkg::HalfQnan : (sgn | 16'h7C00);
            e = int'(b[30:23]) - 112;
            if (e >= 31) return sgn | 16'h7C00;
            if (e <= 0) begin
                if (e < -10) return sgn;
                m   = {8'b0, 1'b1, b[22:0]};
                sh  = 14 - e;
                h   = m >> sh;
                rem = m & ((32'd1 << sh) - 1);
                hf  = 32'd1 << (sh - 1);
            end else begin
                h   = (32'(e) << 10) | (b[22:0] >> 13);
                rem = b[12:0];
                hf  = 32'h1000;
            end
            if (rem > hf || (rem == hf && h[0])) h++;
            return sgn | h[15:0];
        endfunction

        function void subblock(int j, output int sc, output int mn);
            if (j < 4) begin
                sc = subs[j] & 63;
                mn = subs[j+4] & 63;
            end else begin
                sc = (subs[j+4] & 4'hF) | ((subs[j-4] >> 6) << 4);
                mn = (subs[j+4] >> 4) | ((subs[j] >> 6) << 4);
            end
        endfunction

        function void note_byte(logic [7:0] b, logic fin);
            int    c, l, sc, mn, q, hi;
            real   d, dm, v;
            t_elem e;
            if (pos == 0) scale_h[7:0] = b;
            else if (pos == 1) scale_h[15:8] = b;
            else if (pos == 2) min_h[7:0] = b;
            else if (pos == 3) min_h[15:8] = b;
            else if (pos < q4k_pkg::HdrBytes) subs[pos-4] = b;
            else begin
                c = (pos - q4k_pkg::HdrBytes) / q4k_pkg::ChunkBytes;
                l = (pos - q4k_pkg::HdrBytes) % q4k_pkg::ChunkBytes;
                chunk[l] = b;
                if (l == q4k_pkg::ChunkBytes - 1) begin
                    d  = half_to_real(scale_h);
                    dm = half_to_real(min_h);
                    for (int k = 0; k < q4k_pkg::RunLen; k++) begin
                        hi = k / q4k_pkg::ChunkBytes;
                        subblock(2*c + hi, sc, mn);
                        q = hi ? (chunk[k%32] >> 4) : (chunk[k%32] & 4'hF);
                        v = (d * sc) * q - dm * mn;
                        e.half_value    = f32_to_half(real_to_f32(v));
                        e.element_index = 8'(c * q4k_pkg::RunLen + k);
                        e.run_last      = (k == q4k_pkg::RunLen - 1);
                        e.tensor_end    = (k == q4k_pkg::RunLen - 1) && (c == 3) && fin;
                        pending_q.push_back(e);
                    end
                end
            end
            pos = (pos + 1) % q4k_pkg::SbBytes;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h want %h", what, got, want);
            n_fail++;
        endtask

        task check(logic [15:0] hv, logic [7:0] idx, logic rl, logic te);
            t_elem e;
            if (pending_q.size() == 0) begin
                report("unexpected word", {16'b0, hv}, 0);
                return;
            end
            e = pending_q.pop_front();
            if (hv !== e.half_value) report("half_value", hv, e.half_value);
            if (idx !== e.element_index) report("element_index", idx, e.element_index);
            if (rl !== e.run_last) report("run_last", rl, e.run_last);
            if (te !== e.tensor_end) report("tensor_end", te, e.tensor_end);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 0;
    logic        i_final_block = 0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    logic [15:0] o_half_value;
    logic [7:0]  o_element_index;
    logic        o_run_last;
    logic        o_tensor_end;

    q4k_superblock_dequantizer_core u_top (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    dequant_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 0;
    int  quiet_cycles = 0;
    logic [7:0] blk [q4k_pkg::SbBytes];

    task send_byte(logic [7:0] b, logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1;
        i_data_byte   <= b;
        i_final_block <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(b, fin);
    endtask

    function logic [15:0] pick_half();
        logic [15:0] specials [8] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00,
                                      16'h7E00, 16'h0001, 16'h03FF, 16'h7BFF};
        int r;
        r = $urandom_range(99);
        if (r < 10) return specials[$urandom_range(7)];
        if (r < 25) return 16'($urandom);
        return {1'($urandom), 5'($urandom_range(20, 5)), 10'($urandom)};
    endfunction

    task fill_block();
        logic [15:0] s, m;
        s = pick_half();
        m = pick_half();
        blk[0] = s[7:0];
        blk[1] = s[15:8];
        blk[2] = m[7:0];
        blk[3] = m[15:8];
        for (int i = 4; i < q4k_pkg::SbBytes; i++) blk[i] = 8'($urandom);
    endtask

    task send_range(int lo, int hi, logic fin);
        for (int i = lo; i < hi; i++) send_byte(blk[i], fin);
    endtask

    // receiver: check accepted words, then choose next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check(o_half_value, o_element_index, o_run_last, o_tensor_end);
        i_out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any word moving
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        sb.clear();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed block: max scale, smallest subnormal min, sub-scale and sub-min bytes
        // alternating 0xC0 and 0xFF, nibble extremes in the chunks
        blk[0] = 8'hFF; blk[1] = 8'h7B; blk[2] = 8'h01; blk[3] = 8'h80;
        for (int i = 4; i < q4k_pkg::HdrBytes; i++) blk[i] = (i % 2) ? 8'hFF : 8'hC0;
        for (int i = q4k_pkg::HdrBytes; i < q4k_pkg::SbBytes; i++) begin
            case (i % 4)
                0: blk[i] = 8'h00;
                1: blk[i] = 8'hFF;
                2: blk[i] = 8'h0F;
                default: blk[i] = 8'hF0;
            endcase
        end
        send_range(0, 64, 1'b0);

        // long receiver hold-off while the sender keeps offering bytes
        fork
            begin
                hold_off = 1;
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
            end
        join_none
        send_range(64, 96, 1'b0);
        send_idle_pct = 65;
        send_range(96, q4k_pkg::SbBytes, 1'b0);

        // last super-block of the tensor
        send_idle_pct = 0;
        recv_stall_pct = 65;
        fill_block();
        send_range(0, 80, 1'b1);
        send_idle_pct = 22;
        recv_stall_pct = 22;
        send_range(80, q4k_pkg::SbBytes, 1'b1);
        i_in_valid <= 0;

        while (hold_off || sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
